@@ rtl/prle_pkg.sv @@
package prle_pkg;

    localparam int RUN_LEN_W      = 13;
    localparam int IDX_W          = 7;
    localparam int COLOUR_W       = 24;
    localparam int LEN_LIMIT      = 8191;
    localparam int DEF_MAX_ROW    = 4096;
    localparam int DEF_PAL_DEPTH  = 64;

    typedef struct packed {
        logic accept;   // take a pixel word into the run tracker
        logic read;     // read palette entry at the scan pointer
        logic compare;  // compare read data against run colour
        logic step;     // advance scan pointer
        logic emit;     // load output register, append colour if new and palette not full
        logic load_b;   // load the row-end flush run from the open run
    } prle_cmd_t;

    typedef struct packed {
        logic acc_emit;   // accepted pixel closes a run or ends a row
        logic fill_zero;
        logic match;
        logic scan_last;
        logic out_free;
        logic pend_b;
    } prle_status_t;

endpackage

@@ rtl/pixel_row_rle_with_palette_unit.sv @@
// Row run-length encoder with a first-appearance colour palette. Pixel words
// that only extend or open a run are taken one per cycle while no palette
// lookup is under way. A word that closes a run or ends a row stalls input
// while the palette is scanned for the run's colour (scan stops at the first
// match, else runs over all stored colours; an empty palette is not scanned).
// A row-end word that also closes a run then scans again for the flushed run.
// Results sit in an output register, so the next pixel word is taken while a
// result waits; a result that finds the register still held by a stalled word
// waits for it to drain. The palette needs no clearing after reset; only
// stored entries are ever read.
module pixel_row_rle_with_palette_unit #(
    parameter int MAX_ROW_PIXELS = prle_pkg::DEF_MAX_ROW,
    parameter int PALETTE_DEPTH  = prle_pkg::DEF_PAL_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     pixel_blue,
    input  logic [7:0]                     pixel_green,
    input  logic [7:0]                     pixel_red,
    input  logic                           row_end,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     run_blue,
    output logic [7:0]                     run_green,
    output logic [7:0]                     run_red,
    output logic [prle_pkg::RUN_LEN_W-1:0] run_length,
    output logic [prle_pkg::IDX_W-1:0]     palette_index,
    output logic                           colour_is_new,
    output logic                           palette_overflow,
    output logic                           row_last_run,
    output logic                           last_of_item
);
    import prle_pkg::*;

    localparam logic [IDX_W-1:0] OVF_IDX = IDX_W'(PALETTE_DEPTH);

    prle_cmd_t    cmd;
    prle_status_t st;

    prle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    prle_datapath #(
        .MAX_ROW_PIXELS (MAX_ROW_PIXELS),
        .PALETTE_DEPTH  (PALETTE_DEPTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .pixel_blue       (pixel_blue),
        .pixel_green      (pixel_green),
        .pixel_red        (pixel_red),
        .row_end          (row_end),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .run_blue         (run_blue),
        .run_green        (run_green),
        .run_red          (run_red),
        .run_length       (run_length),
        .palette_index    (palette_index),
        .colour_is_new    (colour_is_new),
        .palette_overflow (palette_overflow),
        .row_last_run     (row_last_run),
        .last_of_item     (last_of_item)
    );

    a_new_xor_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(colour_is_new && palette_overflow))
        else $error("run marked both new and overflowed");

    a_row_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && row_last_run) |-> last_of_item)
        else $error("row flush run not last of its word");

    a_ovf_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && palette_overflow) |-> (palette_index == OVF_IDX))
        else $error("overflow run with a stored index");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (run_length != '0))
        else $error("empty run emitted");

endmodule

@@ rtl/prle_ctrl.sv @@
module prle_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  prle_pkg::prle_status_t st,
    output prle_pkg::prle_cmd_t    cmd
);
    import prle_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
                if (in_valid && st.acc_emit)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (st.fill_zero)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.read   = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                cmd.compare = 1'b1;
                if (st.match || st.scan_last)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (st.pend_b)
                    begin
                        cmd.load_b = 1'b1;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/prle_datapath.sv @@
module prle_datapath #(
    parameter int MAX_ROW_PIXELS = prle_pkg::DEF_MAX_ROW,
    parameter int PALETTE_DEPTH  = prle_pkg::DEF_PAL_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  prle_pkg::prle_cmd_t           cmd,
    output prle_pkg::prle_status_t        st,
    input  logic [7:0]                    pixel_blue,
    input  logic [7:0]                    pixel_green,
    input  logic [7:0]                    pixel_red,
    input  logic                          row_end,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    run_blue,
    output logic [7:0]                    run_green,
    output logic [7:0]                    run_red,
    output logic [prle_pkg::RUN_LEN_W-1:0] run_length,
    output logic [prle_pkg::IDX_W-1:0]    palette_index,
    output logic                          colour_is_new,
    output logic                          palette_overflow,
    output logic                          row_last_run,
    output logic                          last_of_item
);
    import prle_pkg::*;

    localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int FILL_W = $clog2(PALETTE_DEPTH + 1);
    localparam int LEN_CAP = (MAX_ROW_PIXELS > LEN_LIMIT) ? LEN_LIMIT : MAX_ROW_PIXELS;
    localparam logic [RUN_LEN_W-1:0] LEN_CAP_V = RUN_LEN_W'(LEN_CAP);
    localparam logic [FILL_W-1:0]    DEPTH_V   = FILL_W'(PALETTE_DEPTH);

    logic [COLOUR_W-1:0]  mem [PALETTE_DEPTH];

    logic [COLOUR_W-1:0]  open_col_reg, open_col_next;
    logic [RUN_LEN_W-1:0] open_cnt_reg, open_cnt_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic                 pend_b_reg, pend_b_next;
    logic                 found_reg, found_next;
    logic [ADDR_W-1:0]    scan_reg, scan_next;
    logic                 out_valid_reg, out_valid_next;

    logic [COLOUR_W-1:0]  run_col_reg;
    logic [RUN_LEN_W-1:0] run_len_reg;
    logic                 run_row_last_reg;
    logic                 run_last_reg;
    logic [COLOUR_W-1:0]  rd_data_reg;

    logic [COLOUR_W-1:0]  out_col_reg;
    logic [RUN_LEN_W-1:0] out_len_reg;
    logic [IDX_W-1:0]     out_idx_reg;
    logic                 out_new_reg;
    logic                 out_ovf_reg;
    logic                 out_row_last_reg;
    logic                 out_last_reg;

    logic [COLOUR_W-1:0]  pix;
    logic                 same;
    logic                 close;
    logic [RUN_LEN_W-1:0] cnt_upd;
    logic                 full;
    logic                 append;
    logic [FILL_W-1:0]    idx_sel;

    assign pix     = {pixel_red, pixel_green, pixel_blue};
    assign same    = (open_cnt_reg != '0) && (open_col_reg == pix);
    assign close   = (open_cnt_reg != '0) && !same;
    assign cnt_upd = !same ? RUN_LEN_W'(1)
                   : (open_cnt_reg < LEN_CAP_V) ? open_cnt_reg + RUN_LEN_W'(1)
                   : open_cnt_reg;
    assign full    = (fill_reg == DEPTH_V);
    assign append  = cmd.emit && !found_reg && !full;

    always_comb
    begin
        priority if (found_reg)
            idx_sel = FILL_W'(scan_reg);
        else if (!full)
            idx_sel = fill_reg;
        else
            idx_sel = DEPTH_V;
    end

    assign st.acc_emit  = close || row_end;
    assign st.fill_zero = (fill_reg == '0);
    assign st.match     = (rd_data_reg == run_col_reg);
    assign st.scan_last = (FILL_W'(scan_reg) + FILL_W'(1)) == fill_reg;
    assign st.out_free  = !out_valid_reg || !out_stall;
    assign st.pend_b    = pend_b_reg;

    // control state
    always_comb
    begin
        open_col_next  = open_col_reg;
        open_cnt_next  = open_cnt_reg;
        fill_next      = fill_reg;
        pend_b_next    = pend_b_reg;
        found_next     = found_reg;
        scan_next      = scan_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cmd.accept)
        begin
            found_next = 1'b0;
            scan_next  = '0;
            if (close)
            begin
                pend_b_next   = row_end;
                open_col_next = pix;
                open_cnt_next = RUN_LEN_W'(1);
            end
            else if (row_end)
            begin
                pend_b_next   = 1'b0;
                open_col_next = '0;
                open_cnt_next = '0;
            end
            else
            begin
                pend_b_next   = 1'b0;
                open_col_next = pix;
                open_cnt_next = cnt_upd;
            end
        end
        if (cmd.compare && st.match)
        begin
            found_next = 1'b1;
        end
        if (cmd.step)
        begin
            scan_next = scan_reg + ADDR_W'(1);
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            if (append)
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
        if (cmd.load_b)
        begin
            found_next    = 1'b0;
            scan_next     = '0;
            pend_b_next   = 1'b0;
            open_col_next = '0;
            open_cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_col_reg  <= '0;
            open_cnt_reg  <= '0;
            fill_reg      <= '0;
            pend_b_reg    <= 1'b0;
            found_reg     <= 1'b0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            open_col_reg  <= open_col_next;
            open_cnt_reg  <= open_cnt_next;
            fill_reg      <= fill_next;
            pend_b_reg    <= pend_b_next;
            found_reg     <= found_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // run being looked up
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            if (close)
            begin
                run_col_reg      <= open_col_reg;
                run_len_reg      <= open_cnt_reg;
                run_row_last_reg <= 1'b0;
                run_last_reg     <= !row_end;
            end
            else if (row_end)
            begin
                run_col_reg      <= pix;
                run_len_reg      <= cnt_upd;
                run_row_last_reg <= 1'b1;
                run_last_reg     <= 1'b1;
            end
        end
        else if (cmd.load_b)
        begin
            run_col_reg      <= open_col_reg;
            run_len_reg      <= open_cnt_reg;
            run_row_last_reg <= 1'b1;
            run_last_reg     <= 1'b1;
        end
    end

    // palette memory, one port each way
    always_ff @(posedge clk)
    begin
        if (append)
        begin
            mem[fill_reg[ADDR_W-1:0]] <= run_col_reg;
        end
        if (cmd.read)
        begin
            rd_data_reg <= mem[scan_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_col_reg      <= run_col_reg;
            out_len_reg      <= run_len_reg;
            out_idx_reg      <= IDX_W'(idx_sel);
            out_new_reg      <= append;
            out_ovf_reg      <= !found_reg && full;
            out_row_last_reg <= run_row_last_reg;
            out_last_reg     <= run_last_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign run_blue         = out_col_reg[7:0];
    assign run_green        = out_col_reg[15:8];
    assign run_red          = out_col_reg[23:16];
    assign run_length       = out_len_reg;
    assign palette_index    = out_idx_reg;
    assign colour_is_new    = out_new_reg;
    assign palette_overflow = out_ovf_reg;
    assign row_last_run     = out_row_last_reg;
    assign last_of_item     = out_last_reg;

endmodule
